// ===== design/bmhq_pkg.sv =====
// Shared constants, codes and controller/datapath bundles for the heap queue.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

    // Fixed field widths.
    localparam int PAY_W      = 32;
    localparam int CNT_W      = 7;
    localparam int CAP_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEFAULT     = 64;
    localparam int KEY_WIDTH_DEFAULT = 32;

    // Register reset values.
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED   = 2'd1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_PULL   = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_KEEP   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_WORSE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_ROOT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_req;   // capture the request beat
        logic    start_up;    // hole at the end, count up
        logic    pull_last;   // count down, last entry becomes the mover
        logic    take_root;   // capture the root for the result
        logic    at_zero;     // hole at the root
        logic    rd_root;     // read root and last entry
        logic    rd_parent;   // read the parent of the hole
        logic    rd_kids;     // read both children of the hole
        logic    move_up;     // parent drops into the hole
        logic    move_down;   // picked child rises into the hole
        logic    wr_final;    // mover lands in the hole
        logic    set_status;
        status_t status;
        logic    load_rsp;    // fill the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        command_t command;
        logic     full;
        logic     empty;
        logic     at_root;
        logic     has_child;
        logic     up_go;
        logic     down_go;
        logic     better;
        logic     rsp_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/bmhq_ifs.sv =====
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface bmhq_req_if
    import bmhq_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic [KEY_WIDTH-1:0] key;
    logic [PAY_W-1:0]     payload;

    modport source (output valid, command, key, payload, input ready);
    modport sink   (input valid, command, key, payload, output ready);
endinterface

interface bmhq_rsp_if
    import bmhq_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [KEY_WIDTH-1:0] out_key;
    logic [PAY_W-1:0]     out_payload;
    logic [CNT_W-1:0]     occupancy;

    modport source (output valid, status, out_key, out_payload, occupancy, input ready);
    modport sink   (input valid, status, out_key, out_payload, occupancy, output ready);
endinterface

interface bmhq_cfg_if
    import bmhq_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/binary_max_heap_queue.sv =====
// Top level of the binary max-heap priority queue with its configuration registers.
//
//  Channel   Side   Beat contents
//  request   sink   command, key, payload
//  response  source status, out_key, out_payload, occupancy
//  cfg       sink   index, data (capacity at index 0, signed_keys at index 1)
//
// One command at a time: a new request is accepted only in the idle state. Insert
// sifts up from the end toward the root until a compare stops it; pull and a
// replacing keep-smallest sift down from the root. Each sift moves at most
// log2(DEPTH) levels. Peek, a discarded keep-smallest and a full or empty report move
// no entry. Each level moved is a registered memory read followed by a compare and
// write. Reset empties the heap at once; entries hold no reset value. The next
// request is accepted while a stalled response holds its beat, and that command then
// waits in its response state until the stalled beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bmhq_req_if.sink   request,
    bmhq_rsp_if.source response,
    bmhq_cfg_if.sink   cfg
);

    logic [CAP_W-1:0] capacity_reg;
    logic             signed_reg;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    // Configuration registers, always ready.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            signed_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_CAPACITY)
            begin
                capacity_reg <= cfg.data;
            end
            else if (cfg.index == REG_SIGNED)
            begin
                signed_reg <= cfg.data[0];
            end
        end
    end

    // Controller.
    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath.
    bmhq_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_command   (request.command),
        .req_key       (request.key),
        .req_payload   (request.payload),
        .capacity      (capacity_reg),
        .signed_keys   (signed_reg),
        .rsp_ready     (response.ready),
        .rsp_valid     (response.valid),
        .rsp_status    (response.status),
        .rsp_key       (response.out_key),
        .rsp_payload   (response.out_payload),
        .rsp_occupancy (response.occupancy)
    );

endmodule

`default_nettype wire

// ===== design/bmhq_ctrl.sv =====
// Controller state machine that sequences heap commands and sift walks.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        req_ready  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                cmd.rd_root = 1'b1;
                unique case (stat.command)
                    CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            cmd.start_up = 1'b1;
                            state_next   = S_UP_RD;
                        end
                    end
                    CMD_PULL, CMD_PEEK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_EMPTY;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            state_next = S_ROOT;
                        end
                    end
                    CMD_KEEP:
                    begin
                        if (stat.full)
                        begin
                            state_next = S_ROOT;
                        end
                        else
                        begin
                            cmd.start_up = 1'b1;
                            state_next   = S_UP_RD;
                        end
                    end
                endcase
            end

            // Root and last entry are on the read ports here.
            S_ROOT:
            begin
                unique case (stat.command)
                    CMD_PULL:
                    begin
                        cmd.take_root = 1'b1;
                        cmd.pull_last = 1'b1;
                        state_next    = S_DN_RD;
                    end
                    CMD_PEEK:
                    begin
                        cmd.take_root = 1'b1;
                        state_next    = S_RESP;
                    end
                    CMD_KEEP:
                    begin
                        if (stat.better)
                        begin
                            cmd.at_zero = 1'b1;
                            state_next  = S_DN_RD;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_WORSE;
                            state_next     = S_RESP;
                        end
                    end
                    CMD_INSERT:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_UP_RD:
            begin
                if (stat.at_root)
                begin
                    cmd.wr_final = 1'b1;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                if (stat.up_go)
                begin
                    cmd.move_up = 1'b1;
                    state_next  = S_UP_RD;
                end
                else
                begin
                    cmd.wr_final = 1'b1;
                    state_next   = S_RESP;
                end
            end

            S_DN_RD:
            begin
                if (stat.has_child)
                begin
                    cmd.rd_kids = 1'b1;
                    state_next  = S_DN_CMP;
                end
                else
                begin
                    cmd.wr_final = 1'b1;
                    state_next   = S_RESP;
                end
            end

            S_DN_CMP:
            begin
                if (stat.down_go)
                begin
                    cmd.move_down = 1'b1;
                    state_next    = S_DN_RD;
                end
                else
                begin
                    cmd.wr_final = 1'b1;
                    state_next   = S_RESP;
                end
            end

            S_RESP:
            begin
                if (stat.rsp_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/bmhq_dp.sv =====
// Datapath: entry memory, hole pointer, entry count, key compares and result register.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_dp
    import bmhq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    input  wire logic [1:0]           req_command,
    input  wire logic [KEY_WIDTH-1:0] req_key,
    input  wire logic [PAY_W-1:0]     req_payload,
    input  wire logic [CAP_W-1:0]     capacity,
    input  wire logic                 signed_keys,
    input  wire logic                 rsp_ready,
    output logic                      rsp_valid,
    output logic [1:0]                rsp_status,
    output logic [KEY_WIDTH-1:0]      rsp_key,
    output logic [PAY_W-1:0]          rsp_payload,
    output logic [CNT_W-1:0]          rsp_occupancy
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
    localparam int ENT_W  = KEY_WIDTH + PAY_W;

    // Unsigned or two's complement compare, a strictly below b.
    function automatic logic key_less(
        input logic [KEY_WIDTH-1:0] a,
        input logic [KEY_WIDTH-1:0] b,
        input logic                 sgn
    );
        logic [KEY_WIDTH-1:0] flip;
        flip = {sgn, {(KEY_WIDTH-1){1'b0}}};
        return (a ^ flip) < (b ^ flip);
    endfunction

    // Entry memory, one write port and two registered read ports.
    logic [ENT_W-1:0] mem [DEPTH];

    command_t              cmd_reg;
    logic [KEY_WIDTH-1:0]  e_key_reg;
    logic [PAY_W-1:0]      e_pay_reg;
    logic [ADDR_W-1:0]     at_reg;
    logic [CNT_W-1:0]      count_reg;
    status_t               status_reg;
    logic [KEY_WIDTH-1:0]  out_key_reg;
    logic [PAY_W-1:0]      out_pay_reg;
    logic [ENT_W-1:0]      rd_a_reg;
    logic [ENT_W-1:0]      rd_b_reg;

    logic                  rsp_valid_reg;
    status_t               rsp_status_reg;
    logic [KEY_WIDTH-1:0]  rsp_key_reg;
    logic [PAY_W-1:0]      rsp_pay_reg;
    logic [CNT_W-1:0]      rsp_occ_reg;

    logic [IDX_W-1:0]      at_w;
    logic [IDX_W-1:0]      n_w;
    logic [IDX_W-1:0]      left_w;
    logic [IDX_W-1:0]      right_w;
    logic [IDX_W-1:0]      parent_w;
    logic [IDX_W-1:0]      last_w;
    logic                  right_ok;
    logic [CNT_W-1:0]      cap_eff;
    logic [KEY_WIDTH-1:0]  a_key;
    logic [KEY_WIDTH-1:0]  b_key;
    logic                  pick_right;
    logic [ENT_W-1:0]      pick_ent;
    logic [ADDR_W-1:0]     pick_idx;
    logic [ADDR_W-1:0]     addr_a;
    logic [ADDR_W-1:0]     addr_b;
    logic                  wr_en;
    logic [ENT_W-1:0]      wr_data;

    // Tree index arithmetic around the hole.
    always_comb
    begin
        at_w     = IDX_W'(at_reg);
        n_w      = IDX_W'(count_reg);
        left_w   = (at_w << 1) + IDX_W'(1);
        right_w  = left_w + IDX_W'(1);
        parent_w = (at_w - IDX_W'(1)) >> 1;
        last_w   = n_w - IDX_W'(1);
        right_ok = right_w < n_w;
    end

    // Child pick: the right child, when it exists, wins when the left is not larger, ties included.
    always_comb
    begin
        a_key      = rd_a_reg[ENT_W-1:PAY_W];
        b_key      = rd_b_reg[ENT_W-1:PAY_W];
        pick_right = right_ok && !key_less(b_key, a_key, signed_keys);
        pick_ent   = pick_right ? rd_b_reg : rd_a_reg;
        pick_idx   = pick_right ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];
    end

    // Read address selection.
    always_comb
    begin
        priority if (cmd.rd_parent)
        begin
            addr_a = parent_w[ADDR_W-1:0];
            addr_b = last_w[ADDR_W-1:0];
        end
        else if (cmd.rd_kids)
        begin
            addr_a = left_w[ADDR_W-1:0];
            addr_b = right_w[ADDR_W-1:0];
        end
        else if (cmd.rd_root)
        begin
            addr_a = '0;
            addr_b = last_w[ADDR_W-1:0];
        end
        else
        begin
            addr_a = '0;
            addr_b = '0;
        end
    end

    // Write port selection.
    always_comb
    begin
        wr_en = cmd.move_up || cmd.move_down || cmd.wr_final;
        priority if (cmd.move_up)
        begin
            wr_data = rd_a_reg;
        end
        else if (cmd.move_down)
        begin
            wr_data = pick_ent;
        end
        else
        begin
            wr_data = {e_key_reg, e_pay_reg};
        end
    end

    // Entry memory access.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[at_reg] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // Status toward the controller.
    always_comb
    begin
        cap_eff        = (capacity == '0) ? CNT_W'(1) : capacity;
        stat.command   = cmd_reg;
        stat.full      = (count_reg >= cap_eff) || (int'(count_reg) >= DEPTH);
        stat.empty     = (count_reg == '0);
        stat.at_root   = (at_reg == '0);
        stat.has_child = at_w < (n_w >> 1);
        stat.up_go     = key_less(a_key, e_key_reg, signed_keys);
        stat.down_go   = key_less(e_key_reg, pick_ent[ENT_W-1:PAY_W], signed_keys);
        stat.better    = key_less(e_key_reg, a_key, signed_keys);
        stat.rsp_free  = !rsp_valid_reg || rsp_ready;
    end

    // Mover entry, hole pointer and result fields (no reset needed).
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            cmd_reg     <= command_t'(req_command);
            e_key_reg   <= req_key;
            e_pay_reg   <= req_payload;
            status_reg  <= ST_OK;
            out_key_reg <= '0;
            out_pay_reg <= '0;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.take_root)
        begin
            out_key_reg <= a_key;
            out_pay_reg <= rd_a_reg[PAY_W-1:0];
        end
        if (cmd.pull_last)
        begin
            e_key_reg <= b_key;
            e_pay_reg <= rd_b_reg[PAY_W-1:0];
        end
        if (cmd.start_up)
        begin
            at_reg <= n_w[ADDR_W-1:0];
        end
        else if (cmd.at_zero || cmd.pull_last)
        begin
            at_reg <= '0;
        end
        else if (cmd.move_up)
        begin
            at_reg <= parent_w[ADDR_W-1:0];
        end
        else if (cmd.move_down)
        begin
            at_reg <= pick_idx;
        end
        if (cmd.load_rsp)
        begin
            rsp_status_reg <= status_reg;
            rsp_key_reg    <= out_key_reg;
            rsp_pay_reg    <= out_pay_reg;
            rsp_occ_reg    <= count_reg;
        end
    end

    // Entry count and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_up)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.pull_last)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign rsp_status    = rsp_status_reg;
    assign rsp_key       = rsp_key_reg;
    assign rsp_payload   = rsp_pay_reg;
    assign rsp_occupancy = rsp_occ_reg;

endmodule

`default_nettype wire

// ===== design/bmhq_chk.sv =====
// Port-level checker for the heap queue and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_chk
    import bmhq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
)
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic [1:0]           rsp_status,
    input wire logic [KEY_WIDTH-1:0] rsp_key,
    input wire logic [PAY_W-1:0]     rsp_payload,
    input wire logic [CNT_W-1:0]     rsp_occupancy
);

    // A stalled response beat holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_key) && $stable(rsp_payload) && $stable(rsp_occupancy))
        else $error("response beat changed while stalled");

    // The queue works on one command at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a command is in progress");

    // Occupancy never passes the storage depth.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_occupancy) <= DEPTH)
        else $error("occupancy beyond depth");

    // An empty report means nothing is held and no entry is returned.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |->
            rsp_occupancy == '0 && rsp_key == '0 && rsp_payload == '0)
        else $error("empty status with entries or data");

    // Dropped or discarded inserts return no entry.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_WORSE) |->
            rsp_key == '0 && rsp_payload == '0)
        else $error("rejected insert returned data");

endmodule

bind binary_max_heap_queue bmhq_chk #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
) u_bmhq_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (request.valid),
    .req_ready     (request.ready),
    .rsp_valid     (response.valid),
    .rsp_ready     (response.ready),
    .rsp_status    (response.status),
    .rsp_key       (response.out_key),
    .rsp_payload   (response.out_payload),
    .rsp_occupancy (response.occupancy)
);

`default_nettype wire
